// ----- sv/lru_pkg.sv -----
// Shared types and codes for the recency list.
`default_nettype none
package lru_pkg;

  localparam int KEY_W = 32;
  localparam int HND_W = 8;
  localparam int POS_W = 5;
  localparam int ENT_W = 5;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_TOUCH       = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE      = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND_KEY    = 2'd2;
  localparam logic [OP_W-1:0] OP_FIND_HANDLE = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NEW       = 2'd3;

  localparam logic [HND_W-1:0] HANDLE_FIRST = 8'd1;
  localparam logic [HND_W-1:0] HANDLE_LAST  = 8'd255;

  typedef struct packed {
    logic capture;
    logic compare;
    logic select;
    logic commit;
  } lru_cmd_t;

endpackage
`default_nettype wire

// ----- sv/lru_recency_list.sv -----
// An accepted input passes the compare, select and commit states before its result is
// shown on the master side; these steps over the entry row run one after another, and
// the next input is taken in the cycle its result leaves.
// One item is in work at a time; a stalled result holds the next input off.
// Reset (rst, synchronous): table empty, handle counter at 1; ready as soon as rst drops.
`default_nettype none
module lru_recency_list
  import lru_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // device_key[31:0], handle_in[39:32]
  input  wire logic [1:0]  s_tuser,  // operation[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [55:0]      m_tdata,  // handle_out[7:0], position[12:8], key_out[44:13],
                                     // entries_used[49:45], zero[55:50]
  output logic [1:0]       m_tuser   // status[1:0]
);

  lru_cmd_t         cmd;
  logic [ST_W-1:0]  status;
  logic [HND_W-1:0] handle_out;
  logic [POS_W-1:0] position;
  logic [KEY_W-1:0] key_out;
  logic [ENT_W-1:0] entries_used;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lru_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .op_in        (s_tuser),
    .key_in       (s_tdata[31:0]),
    .hin_in       (s_tdata[39:32]),
    .status       (status),
    .handle_out   (handle_out),
    .position     (position),
    .key_out      (key_out),
    .entries_used (entries_used)
  );

  assign m_tdata = {6'd0, entries_used, key_out, position, handle_out};
  assign m_tuser = status;

endmodule
`default_nettype wire

// ----- sv/lru_dp.sv -----
// Datapath: entry row, parallel compare, first-match select, shift update and result register.
`default_nettype none
module lru_dp
  import lru_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lru_cmd_t         cmd,
  input  wire logic [OP_W-1:0]  op_in,
  input  wire logic [KEY_W-1:0] key_in,
  input  wire logic [HND_W-1:0] hin_in,
  output logic [ST_W-1:0]       status,
  output logic [HND_W-1:0]      handle_out,
  output logic [POS_W-1:0]      position,
  output logic [KEY_W-1:0]      key_out,
  output logic [ENT_W-1:0]      entries_used
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [KEY_W-1:0] keys [DEPTH];
  logic [HND_W-1:0] handles [DEPTH];
  logic [KEY_W-1:0] keys_next [DEPTH];
  logic [HND_W-1:0] handles_next [DEPTH];
  logic [CW-1:0]    count, count_next;
  logic [HND_W-1:0] next_handle, next_handle_next;

  logic [OP_W-1:0]  op_r;
  logic [KEY_W-1:0] key_r;
  logic [HND_W-1:0] hin_r;

  logic [DEPTH-1:0] match, match_r;
  logic [DEPTH-1:0] first_hit;
  logic [PW-1:0]    pos_sel, pos_r;
  logic [HND_W-1:0] hit_h_sel, hit_h_r;
  logic [KEY_W-1:0] hit_k_sel, hit_k_r;
  logic             found_r;

  logic [ST_W-1:0]  status_next;
  logic [HND_W-1:0] handle_out_next;
  logic [PW-1:0]    pos_out_next;
  logic [KEY_W-1:0] key_out_next;

  // compare stage: key ops match on key, the others on handle; only live slots count
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      if (op_r == OP_TOUCH || op_r == OP_FIND_KEY) begin
        match[i] = (CW'(i) < count) && (keys[i] == key_r);
      end else begin
        match[i] = (CW'(i) < count) && (handles[i] == hin_r);
      end
    end
  end

  // select stage: isolate the match nearest the front
  assign first_hit = match_r & (~match_r + DEPTH'(1));

  always_comb begin
    pos_sel   = '0;
    hit_h_sel = '0;
    hit_k_sel = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        pos_sel = PW'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      hit_h_sel = hit_h_sel | (handles[i] & {HND_W{first_hit[i]}});
      hit_k_sel = hit_k_sel | (keys[i] & {KEY_W{first_hit[i]}});
    end
  end

  // commit stage
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keys_next[i]    = keys[i];
      handles_next[i] = handles[i];
    end
    count_next       = count;
    next_handle_next = next_handle;
    status_next      = ST_NOT_FOUND;
    handle_out_next  = '0;
    pos_out_next     = '0;
    key_out_next     = '0;
    case (op_r)
      OP_TOUCH: begin
        if (found_r) begin
          status_next     = ST_DONE;
          handle_out_next = hit_h_r;
          pos_out_next    = pos_r;
          key_out_next    = key_r;
          keys_next[0]    = key_r;
          handles_next[0] = hit_h_r;
          for (int i = 1; i < DEPTH; i++) begin
            if (PW'(i) <= pos_r) begin
              keys_next[i]    = keys[i-1];
              handles_next[i] = handles[i-1];
            end
          end
        end else if (count == CW'(DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          status_next     = ST_NEW;
          handle_out_next = next_handle;
          key_out_next    = key_r;
          keys_next[0]    = key_r;
          handles_next[0] = next_handle;
          for (int i = 1; i < DEPTH; i++) begin
            keys_next[i]    = keys[i-1];
            handles_next[i] = handles[i-1];
          end
          count_next       = count + CW'(1);
          next_handle_next = (next_handle == HANDLE_LAST) ? HANDLE_FIRST
                                                          : next_handle + HND_W'(1);
        end
      end
      OP_FIND_KEY: begin
        if (found_r) begin
          status_next     = ST_DONE;
          handle_out_next = hit_h_r;
          pos_out_next    = pos_r;
          key_out_next    = key_r;
        end
      end
      OP_DELETE, OP_FIND_HANDLE: begin
        if (found_r) begin
          status_next     = ST_DONE;
          handle_out_next = hit_h_r;
          pos_out_next    = pos_r;
          key_out_next    = hit_k_r;
          if (op_r == OP_DELETE) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
              if (PW'(i) >= pos_r) begin
                keys_next[i]    = keys[i+1];
                handles_next[i] = handles[i+1];
              end
            end
            count_next = count - CW'(1);
          end
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      next_handle <= HANDLE_FIRST;
    end else if (cmd.commit) begin
      count       <= count_next;
      next_handle <= next_handle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= op_in;
      key_r <= key_in;
      hin_r <= hin_in;
    end
    if (cmd.compare) begin
      match_r <= match;
    end
    if (cmd.select) begin
      found_r <= |match_r;
      pos_r   <= pos_sel;
      hit_h_r <= hit_h_sel;
      hit_k_r <= hit_k_sel;
    end
    if (cmd.commit) begin
      for (int i = 0; i < DEPTH; i++) begin
        keys[i]    <= keys_next[i];
        handles[i] <= handles_next[i];
      end
      status       <= status_next;
      handle_out   <= handle_out_next;
      position     <= POS_W'(pos_out_next);
      key_out      <= key_out_next;
      entries_used <= ENT_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_handle_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_handle != '0)
    else $error("handle counter reached zero");

  a_count_only_on_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.commit) |-> count == $past(count))
    else $error("entry count changed outside commit");

  a_new_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && status_next == ST_NEW |=> count == $past(count) + CW'(1))
    else $error("new entry did not grow the table");

endmodule
`default_nettype wire

// ----- sv/lru_ctrl.sv -----
// Controller: sequences compare, select and commit for one transfer at a time.
`default_nettype none
module lru_ctrl
  import lru_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  output lru_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMP  = 3'd1;
  localparam logic [2:0] S_SEL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state, state_next;

  // a new transfer may enter in the same cycle the result leaves
  assign s_tready = (state == S_IDLE) || (state == S_OUT && m_tready);
  assign m_tvalid = (state == S_OUT);

  assign cmd.capture = s_tvalid && s_tready;
  assign cmd.compare = (state == S_CMP);
  assign cmd.select  = (state == S_SEL);
  assign cmd.commit  = (state == S_UPD);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_CMP;
      end
      S_CMP: state_next = S_SEL;
      S_SEL: state_next = S_UPD;
      S_UPD: state_next = S_OUT;
      S_OUT: begin
        if (m_tready) state_next = s_tvalid ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_capture_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == S_IDLE || state == S_OUT)
    else $error("input taken while an item is in work");

  a_commit_then_out: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("result not presented after commit");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire
